### rtl/core/oqsr_pkg.sv
// ----------------------------------------------------------------------------
// Ordered queue package
// Sizes, command and status codes, and the control types shared by the
// controller and the datapath of the ordered queue.
// ----------------------------------------------------------------------------
package oqsr_pkg;

   localparam int DEPTH     = 16;
   localparam int TAG_WIDTH = 16;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);

   localparam int CMD_W = 3;
   localparam int POS_W = 4;
   localparam int ST_W  = 3;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd4;

   localparam logic [ST_W-1:0] ST_OK       = 3'd0;
   localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
   localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
   localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [ST_W-1:0] ST_INDEX    = 3'd4;

   typedef struct packed {
      logic load;
      logic exec;
   } oqsr_ctrl_type;

   typedef struct packed {
      logic out_free;
   } oqsr_stat_type;

endpackage

### rtl/core/oqsr_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered queue controller
// Accepts a command, then waits until the result register is free and
// tells the datapath to carry the command out.
// ----------------------------------------------------------------------------
module oqsr_ctrl
   import oqsr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  oqsr_stat_type stat,
   output oqsr_ctrl_type ctrl
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      ctrl.load  = 1'b0;
      ctrl.exec  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.load = 1'b1;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            if (stat.out_free) begin
               ctrl.exec = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/oqsr_datapath.sv
// ----------------------------------------------------------------------------
// Ordered queue datapath
// A row of tag cells with parallel compare and a shift toward the head,
// the command registers and the result register.
// ----------------------------------------------------------------------------
module oqsr_datapath
   import oqsr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CMD_W-1:0]     req_cmd,
   input  logic [15:0]          req_tag_value,
   input  logic [POS_W-1:0]     req_position,
   input  oqsr_ctrl_type        ctrl,
   output oqsr_stat_type        stat,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [15:0]          rsp_data_out,
   output logic                 rsp_found,
   output logic [ST_W-1:0]      rsp_status,
   output logic [CNT_W-1:0]     rsp_occupancy,
   output logic                 rsp_is_empty
);

   logic [CMD_W-1:0]     cmd_ff;
   logic [TAG_WIDTH-1:0] tag_ff;
   logic [POS_W-1:0]     pos_ff;

   logic [TAG_WIDTH-1:0] slot_ff [DEPTH];
   logic [TAG_WIDTH-1:0] slot_in [DEPTH];
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;

   logic                 valid_ff;
   logic                 valid_in;
   logic [15:0]          data_ff;
   logic [15:0]          data_in;
   logic                 found_ff;
   logic                 found_in;
   logic [ST_W-1:0]      status_ff;
   logic [ST_W-1:0]      status_in;

   logic [DEPTH-1:0]     match;
   logic [DEPTH-1:0]     first;
   logic [DEPTH-1:0]     shift_mask;
   logic                 do_shift;

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         match[i] = (CNT_W'(i) < count_ff) && (slot_ff[i] == tag_ff);
      end
      first = match & (~match + 1'b1);
   end

   always_comb begin
      slot_in    = slot_ff;
      count_in   = count_ff;
      data_in    = '0;
      found_in   = 1'b0;
      status_in  = ST_OK;
      do_shift   = 1'b0;
      shift_mask = '1;
      unique case (cmd_ff)
         CMD_PUSH: begin
            if (count_ff == CNT_W'(DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               slot_in[count_ff[IDX_W-1:0]] = tag_ff;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_POP: begin
            if (count_ff == '0) begin
               status_in = ST_EMPTY;
            end else begin
               data_in  = slot_ff[0];
               do_shift = 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         CMD_READ: begin
            if (CNT_W'(pos_ff) >= count_ff) begin
               status_in = ST_INDEX;
            end else begin
               data_in = slot_ff[pos_ff[IDX_W-1:0]];
            end
         end
         CMD_REMOVE: begin
            if (match == '0) begin
               status_in = ST_NOTFOUND;
            end else begin
               shift_mask = ~(first - 1'b1);
               do_shift   = 1'b1;
               count_in   = count_ff - 1'b1;
            end
         end
         CMD_SEARCH: begin
            found_in = |match;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
      if (do_shift) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (shift_mask[i]) begin
               slot_in[i] = slot_ff[i+1];
            end
         end
      end
   end

   assign stat.out_free = !valid_ff || rsp_tready;
   assign valid_in      = ctrl.exec || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         cmd_ff <= req_cmd;
         tag_ff <= req_tag_value[TAG_WIDTH-1:0];
         pos_ff <= req_position;
      end
      if (ctrl.exec) begin
         slot_ff   <= slot_in;
         data_ff   <= data_in;
         found_ff  <= found_in;
         status_ff <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ctrl.exec) begin
            count_ff <= count_in;
         end
      end
   end

   assign rsp_tvalid    = valid_ff;
   assign rsp_data_out  = data_ff;
   assign rsp_found     = found_ff;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = count_ff;
   assign rsp_is_empty  = (count_ff == '0);

endmodule

### rtl/core/ordered_queue_with_search_remove_unit.sv
// ----------------------------------------------------------------------------
// Ordered queue with search and remove
// Each command is taken into the command register, then carried out in the
// execute state, which writes the result register; a command waits in the
// execute state while an earlier result still waits in the output.
// No new command is taken until the current one has been carried out.
// A new command is taken while a finished result still waits in the output.
// Reset empties the queue and drops any pending result; cell contents are
// left as they are and are only read once written.
// ----------------------------------------------------------------------------
module ordered_queue_with_search_remove_unit
   import oqsr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[2:0], tag_value[18:3], position[22:19], zero[23]
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // data_out[15:0], found[16], status[19:17], occupancy[24:20],
   // is_empty[25], zero[31:26]
   output logic [31:0] rsp_tdata
);

   oqsr_ctrl_type    ctrl;
   oqsr_stat_type    stat;
   logic [15:0]      data_out;
   logic             found;
   logic [ST_W-1:0]  status;
   logic [CNT_W-1:0] occupancy;
   logic             is_empty;

   oqsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   oqsr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_cmd       (req_tdata[2:0]),
      .req_tag_value (req_tdata[18:3]),
      .req_position  (req_tdata[22:19]),
      .ctrl          (ctrl),
      .stat          (stat),
      .rsp_tready    (rsp_tready),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_data_out  (data_out),
      .rsp_found     (found),
      .rsp_status    (status),
      .rsp_occupancy (occupancy),
      .rsp_is_empty  (is_empty)
   );

   assign rsp_tdata = {6'd0, is_empty, occupancy, status, found, data_out};

endmodule

### rtl/core/oqsr_checker.sv
// ----------------------------------------------------------------------------
// Ordered queue port checker
// Watches the ports of the ordered queue and flags results that cannot
// come from a correct queue.
// ----------------------------------------------------------------------------
module oqsr_checker
   import oqsr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("Stalled result transfer changed or dropped.");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[25] == (rsp_tdata[24:20] == 5'd0)))
      else $error("Empty flag disagrees with occupancy.");

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[24:20] <= 5'(DEPTH))
      else $error("Occupancy exceeds queue depth.");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[19:17] == ST_OK && rsp_tdata[15:0] == 16'd0)
      else $error("Search hit carries an error or data.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result offered straight after reset.");

endmodule

bind ordered_queue_with_search_remove_unit oqsr_checker u_oqsr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
